### design/integer_to_padded_text_assert.svh
// Assertion macros for the integer-to-text formatter.
// Used by the top level only; needs nothing else.
`ifndef INTEGER_TO_PADDED_TEXT_ASSERT_SVH
`define INTEGER_TO_PADDED_TEXT_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ITPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define ITPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/itpt_pkg.sv
// Shared constants, types and the digit table of the integer-to-text formatter.
// No dependencies.
`timescale 1ns / 1ps

package itpt_pkg;

   // Field widths of the words on both channels.
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned BASE_W  = 5;
   localparam int unsigned WIDTH_W = 6;
   localparam int unsigned PREC_W  = 6;
   localparam int unsigned FLAGS_W = 7;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned DIGIT_W = 4;

   // Default sizes handed to the top level.
   localparam int unsigned MAX_WIDTH_DEF    = 48;
   localparam int unsigned DIGIT_BUFFER_DEF = 32;

   // The digit divider retires this many quotient bits per cycle.
   localparam int unsigned DIV_BITS  = 8;
   localparam int unsigned DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int unsigned STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Bit positions inside the flags field.
   localparam int unsigned FLAG_ZERO   = 0;
   localparam int unsigned FLAG_SIGNED = 1;
   localparam int unsigned FLAG_PLUS   = 2;
   localparam int unsigned FLAG_SPACE  = 3;
   localparam int unsigned FLAG_PREFIX = 4;
   localparam int unsigned FLAG_LOWER  = 5;
   localparam int unsigned FLAG_LEFT   = 6;

   localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
   localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
   localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

   localparam logic [1:0] PREFIX_NONE = 2'd0;
   localparam logic [1:0] PREFIX_OCT  = 2'd1;
   localparam logic [1:0] PREFIX_HEX  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X     = 8'h58;
   localparam logic [CHAR_W-1:0] CASE_MASK  = 8'h20;

   localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] digit);
      return HEX_DIGITS[digit];
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // controller can take a new word
      logic div_step;   // run one step of the digit divider
      logic digit_end;  // last step of the current digit
      logic size;       // work out padding and digit counts
      logic bound;      // work out the segment boundaries of the text
      logic prime;      // first digit read in flight
      logic emit;       // hand characters to the output register
   } itpt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic accept;     // an input word is taken this cycle
      logic base_ok;    // the incoming base is in range
      logic div_done;   // the quotient after this digit is zero, or the digit store is full
      logic emit_last;  // the final character moves to the output register
   } itpt_stat_type;

endpackage

### design/itpt_req_if.sv
// Input channel of the formatter: one number with its format per word.
// Depends on itpt_pkg.
`timescale 1ns / 1ps

interface itpt_req_if import itpt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   value;
   logic [BASE_W-1:0]    base;
   logic [WIDTH_W-1:0]   width;
   logic [PREC_W-1:0]    precision;
   logic [FLAGS_W-1:0]   flags;

   modport source (output valid, value, base, width, precision, flags, input ready);
   modport sink   (input valid, value, base, width, precision, flags, output ready);
endinterface

### design/itpt_rsp_if.sv
// Result channel of the formatter: one ASCII character per word.
// Depends on itpt_pkg.
`timescale 1ns / 1ps

interface itpt_rsp_if import itpt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   char_out;
   logic                last;

   modport source (output valid, char_out, last, input ready);
   modport sink   (input valid, char_out, last, output ready);
endinterface

### design/itpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module itpt_ram #(
   parameter int unsigned DATA_W = 4,
   parameter int unsigned DEPTH  = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/itpt_controller.sv
// Sequencer of the formatter: divide into digits, size the text, emit it.
// Depends on itpt_pkg.
`timescale 1ns / 1ps

module itpt_controller import itpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  itpt_stat_type stat,
   output itpt_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIZE,
      ST_BOUND,
      ST_PRIME,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              digit_end;

   assign digit_end = (state_ff == ST_DIVIDE) && (step_ff == STEP_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            // A word with a bad base is taken and dropped without any text.
            if (stat.accept && stat.base_ok) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (digit_end) begin
               step_in = '0;
               if (stat.div_done) begin
                  state_in = ST_SIZE;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SIZE:  state_in = ST_BOUND;
         ST_BOUND: state_in = ST_PRIME;
         ST_PRIME: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.take      = (state_ff == ST_IDLE);
      cmd.div_step  = (state_ff == ST_DIVIDE);
      cmd.digit_end = digit_end;
      cmd.size      = (state_ff == ST_SIZE);
      cmd.bound     = (state_ff == ST_BOUND);
      cmd.prime     = (state_ff == ST_PRIME);
      cmd.emit      = (state_ff == ST_EMIT);
   end

endmodule

### design/itpt_datapath.sv
// Datapath of the formatter: digit divider, digit store, text layout and
// output register. Depends on itpt_pkg, itpt_req_if, itpt_rsp_if and itpt_ram.
`timescale 1ns / 1ps

module itpt_datapath import itpt_pkg::*; #(
   parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int unsigned DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  itpt_cmd_type  cmd,
   output itpt_stat_type stat,
   itpt_req_if.sink      req_ch,
   itpt_rsp_if.source    rsp_ch
);

   localparam int unsigned POS_W  = $clog2(MAX_WIDTH + DIGIT_BUFFER + 4);
   localparam int unsigned ND_W   = $clog2(DIGIT_BUFFER + 1);
   localparam int unsigned ADDR_W = $clog2(DIGIT_BUFFER);
   localparam logic [POS_W-1:0] MAX_POS    = POS_W'(MAX_WIDTH);
   localparam logic [POS_W-1:0] PREC_MAX   = POS_W'(DIGIT_BUFFER);
   localparam logic [ND_W-1:0]  DIGIT_LAST = ND_W'(DIGIT_BUFFER - 1);

   // Format of the word in progress.
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [BASE_W-1:0]  base_ff;
   logic [ND_W-1:0]    nd_ff;
   logic [POS_W-1:0]   wid_ff, wid_in;
   logic [POS_W-1:0]   prec_ff, prec_in;
   logic               has_sign_ff, has_sign_in;
   logic [CHAR_W-1:0]  sign_ch_ff, sign_ch_in;
   logic [1:0]         pre_n_ff, pre_n_in;
   logic               lower_ff, left_ff, zero_ff;

   // Layout of the text.
   logic [POS_W-1:0]   pad_ff, pad_in;
   logic [POS_W-1:0]   zp_ff, zp_in;
   logic [POS_W-1:0]   a_ff, a_in;
   logic [POS_W-1:0]   b_ff, b_in;
   logic [POS_W-1:0]   c_ff, c_in;
   logic [POS_W-1:0]   e_ff, e_in;
   logic [POS_W-1:0]   f_ff, f_in;
   logic [POS_W-1:0]   last_idx_ff, last_idx_in;
   logic [POS_W-1:0]   k_ff, k_in;

   // Output register.
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff;

   logic               neg;
   logic [DIGIT_W:0]   trial;
   logic [DIV_BITS-1:0] qbits;
   logic [POS_W-1:0]   nd_ext;
   logic [POS_W-1:0]   dcnt;
   logic signed [POS_W:0] size_s;
   logic [POS_W-1:0]   total;
   logic [POS_W-1:0]   rd_pos;
   logic [CHAR_W-1:0]  case_mask;
   logic [DIGIT_W-1:0] rd_digit;
   logic               can_load;
   logic               fire;

   assign stat.accept    = req_ch.valid && cmd.take;
   assign stat.base_ok   = (req_ch.base >= BASE_MIN) && (req_ch.base <= BASE_MAX);
   assign req_ch.ready   = cmd.take;

   // Capture of a new word: sign, magnitude, prefix and clamped sizes.
   always_comb begin
      neg         = req_ch.flags[FLAG_SIGNED] && req_ch.value[VALUE_W-1];
      has_sign_in = 1'b1;
      priority if (neg) begin
         sign_ch_in = CHAR_MINUS;
      end else if (req_ch.flags[FLAG_SIGNED] && req_ch.flags[FLAG_PLUS]) begin
         sign_ch_in = CHAR_PLUS;
      end else if (req_ch.flags[FLAG_SIGNED] && req_ch.flags[FLAG_SPACE]) begin
         sign_ch_in = CHAR_SPACE;
      end else begin
         sign_ch_in  = CHAR_SPACE;
         has_sign_in = 1'b0;
      end

      pre_n_in = PREFIX_NONE;
      if (req_ch.flags[FLAG_PREFIX]) begin
         if (req_ch.base == BASE_HEX) begin
            pre_n_in = PREFIX_HEX;
         end else if (req_ch.base == BASE_OCT) begin
            pre_n_in = PREFIX_OCT;
         end
      end

      wid_in  = (POS_W'(req_ch.width) > MAX_POS) ? MAX_POS : POS_W'(req_ch.width);
      prec_in = (POS_W'(req_ch.precision) > PREC_MAX) ? PREC_MAX
                                                       : POS_W'(req_ch.precision);
   end

   // Restoring division by the base, DIV_BITS quotient bits per cycle. The
   // remainder stays below the base, so it fits in one digit.
   always_comb begin
      rem_in = rem_ff;
      qbits  = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {rem_in, quot_ff[VALUE_W-1-i]};
         if (trial >= base_ff) begin
            trial                = trial - base_ff;
            qbits[DIV_BITS-1-i] = 1'b1;
         end
         rem_in = trial[DIGIT_W-1:0];
      end
      quot_in = {quot_ff[VALUE_W-DIV_BITS-1:0], qbits};
   end

   assign stat.div_done = (quot_in == '0) || (nd_ff == DIGIT_LAST);

   assign nd_ext = POS_W'(nd_ff);

   // Padding left over after sign, prefix and digits, clamped at zero when negative.
   always_comb begin
      dcnt   = (prec_ff > nd_ext) ? prec_ff : nd_ext;
      size_s = $signed({1'b0, wid_ff})
             - $signed({{POS_W{1'b0}}, has_sign_ff})
             - $signed({{(POS_W-1){1'b0}}, pre_n_ff})
             - $signed({1'b0, dcnt});
      pad_in = (!size_s[POS_W] && (size_s != '0)) ? size_s[POS_W-1:0] : '0;
      zp_in  = dcnt - nd_ext;
   end

   // Segment ends: left spaces, sign, prefix, zeros, digits, right spaces.
   always_comb begin
      a_in  = (zero_ff || left_ff) ? '0 : pad_ff;
      b_in  = a_in + POS_W'(has_sign_ff);
      c_in  = b_in + POS_W'(pre_n_ff);
      e_in  = c_in + (zero_ff ? pad_ff : '0) + zp_ff;
      f_in  = e_in + nd_ext;
      total = f_in + (left_ff ? pad_ff : '0);
      last_idx_in = (total > MAX_POS) ? (MAX_POS - POS_W'(1)) : (total - POS_W'(1));
   end

   assign can_load       = !rsp_valid_ff || rsp_ch.ready;
   assign fire           = cmd.emit && can_load;
   assign stat.emit_last = fire && (k_ff == last_idx_ff);

   always_comb begin
      if (cmd.bound || cmd.prime) begin
         k_in = '0;
      end else if (fire) begin
         k_in = k_ff + POS_W'(1);
      end else begin
         k_in = k_ff;
      end
   end

   // Digits are stored least significant first, so the text reads them
   // backward. The address follows the next index so that the registered
   // read lines up with the current one.
   assign rd_pos = f_ff - POS_W'(1) - k_in;

   itpt_ram #(
      .DATA_W (DIGIT_W),
      .DEPTH  (DIGIT_BUFFER)
   ) u_digits (
      .clock   (clock),
      .wr_en   (cmd.digit_end),
      .wr_addr (nd_ff[ADDR_W-1:0]),
      .wr_data (rem_in),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (rd_digit)
   );

   assign case_mask = lower_ff ? CASE_MASK : '0;

   always_comb begin
      priority if (k_ff < a_ff) begin
         char_in = CHAR_SPACE;
      end else if (k_ff < b_ff) begin
         char_in = sign_ch_ff;
      end else if (k_ff < c_ff) begin
         char_in = (k_ff == b_ff) ? CHAR_ZERO : (CHAR_X | case_mask);
      end else if (k_ff < e_ff) begin
         char_in = CHAR_ZERO;
      end else if (k_ff < f_ff) begin
         char_in = hex_char(rd_digit) | case_mask;
      end else begin
         char_in = CHAR_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.accept) begin
         quot_ff     <= neg ? (VALUE_W'(0) - req_ch.value) : req_ch.value;
         rem_ff      <= '0;
         base_ff     <= req_ch.base;
         nd_ff       <= '0;
         wid_ff      <= wid_in;
         prec_ff     <= prec_in;
         has_sign_ff <= has_sign_in;
         sign_ch_ff  <= sign_ch_in;
         pre_n_ff    <= pre_n_in;
         lower_ff    <= req_ch.flags[FLAG_LOWER];
         left_ff     <= req_ch.flags[FLAG_LEFT];
         zero_ff     <= req_ch.flags[FLAG_ZERO] && !req_ch.flags[FLAG_LEFT];
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= cmd.digit_end ? '0 : rem_in;
         if (cmd.digit_end) begin
            nd_ff <= nd_ff + ND_W'(1);
         end
      end
      if (cmd.size) begin
         pad_ff <= pad_in;
         zp_ff  <= zp_in;
      end
      if (cmd.bound) begin
         a_ff        <= a_in;
         b_ff        <= b_in;
         c_ff        <= c_in;
         e_ff        <= e_in;
         f_ff        <= f_in;
         last_idx_ff <= last_idx_in;
      end
      k_ff <= k_in;
      if (fire) begin
         char_ff <= char_in;
         last_ff <= (k_ff == last_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.char_out = char_ff;
   assign rsp_ch.last     = last_ff;

endmodule

### design/integer_to_padded_text.sv
// Formats one number per input word as printf-style text, one character per word.
// Before the first character the divider produces all digits (1..32), retiring 8 quotient
// bits of the 32-bit value per cycle; the size, bound and prime steps follow.
// One number is formatted at a time, up to MAX_WIDTH characters, and the next is taken once
// its last character is queued; characters leave at one per cycle while the result side is ready.
// Reset is synchronous and clears the sequencer and the output valid; nothing else.
`timescale 1ns / 1ps

`include "integer_to_padded_text_assert.svh"

module integer_to_padded_text import itpt_pkg::*; #(
   parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int unsigned DIGIT_BUFFER = DIGIT_BUFFER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   itpt_req_if.sink    req_ch,
   itpt_rsp_if.source  rsp_ch
);

   itpt_cmd_type  cmd;
   itpt_stat_type stat;

   itpt_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   itpt_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .DIGIT_BUFFER (DIGIT_BUFFER)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The input is never open while characters are still being produced.
   `ITPT_ASSERT_SAME(a_take_excl_emit, clock, reset, req_ch.ready, !cmd.emit, "input open during emission")
   // After the final character is queued the block is open for the next word.
   `ITPT_ASSERT_NEXT(a_last_frees_input, clock, reset, stat.emit_last, req_ch.ready, "not idle after final character")
   // A word with a bad base starts no work.
   `ITPT_ASSERT_NEXT(a_bad_base_dropped, clock, reset, stat.accept && !stat.base_ok, req_ch.ready, "bad base started work")
   // Finishing the last digit leaves the divide phase.
   `ITPT_ASSERT_NEXT(a_div_exit, clock, reset, cmd.digit_end && stat.div_done, !cmd.div_step && !req_ch.ready, "divider did not stop")

endmodule

### tb/integer_to_padded_text_tb.sv
// Self-checking testbench for integer_to_padded_text: directed and random format words.
// Depends on itpt_pkg, itpt_req_if, itpt_rsp_if and the integer_to_padded_text top level.
`timescale 1ns / 1ps

module integer_to_padded_text_tb;
   import itpt_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   // Longest quiet time after the last character: a full 32-digit conversion plus a field.
   localparam int TAIL_CYCLES = 4 * DIGIT_BUFFER_DEF + MAX_WIDTH_DEF + 40;
   localparam int REPORT_LIMIT = 10;

   localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1) << FLAG_ZERO;
   localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1) << FLAG_SIGNED;
   localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1) << FLAG_PLUS;
   localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1) << FLAG_SPACE;
   localparam logic [FLAGS_W-1:0] F_PREFIX = FLAGS_W'(1) << FLAG_PREFIX;
   localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1) << FLAG_LOWER;
   localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1) << FLAG_LEFT;

   localparam logic [CHAR_W-1:0] LOWER_CASE_BIT = 8'h20;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
      logic [WIDTH_W-1:0] width;
      logic [PREC_W-1:0]  precision;
      logic [FLAGS_W-1:0] flags;
   } number_word_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   logic clock;
   logic reset;

   itpt_req_if req_ch ();
   itpt_rsp_if rsp_ch ();

   integer_to_padded_text uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_char_type text_expected [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("integer_to_padded_text_tb failed");
         $finish;
      end
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void report_mismatch(input string what, input logic [31:0] want,
                                           input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
   endfunction

   // Builds the formatted text of one word and queues its characters.
   function automatic void predict_text(input number_word_type w);
      logic [VALUE_W-1:0] mag;
      logic [FLAGS_W-1:0] fl;
      logic [CHAR_W-1:0]  lower_bit;
      logic [CHAR_W-1:0]  pad_ch;
      logic [CHAR_W-1:0]  sign_ch;
      logic               has_sign;
      logic [CHAR_W-1:0]  digits [DIGIT_BUFFER_DEF];
      logic [CHAR_W-1:0]  text [$];
      int radix, field, min_digits, room, ndig, d, count;
      text_char_type tc;

      if (w.base < BASE_MIN || w.base > BASE_MAX)
         return;
      radix = w.base;
      field = (w.width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w.width;
      min_digits = (w.precision > DIGIT_BUFFER_DEF) ? DIGIT_BUFFER_DEF : w.precision;
      fl = w.flags;
      lower_bit = fl[FLAG_LOWER] ? LOWER_CASE_BIT : '0;
      if (fl[FLAG_LEFT])
         fl[FLAG_ZERO] = 1'b0;
      pad_ch = fl[FLAG_ZERO] ? "0" : " ";

      mag = w.value;
      room = field;
      has_sign = 1'b0;
      sign_ch = " ";
      if (fl[FLAG_SIGNED]) begin
         if (mag[VALUE_W-1]) begin
            sign_ch = "-";
            has_sign = 1'b1;
            mag = '0 - mag;
         end else if (fl[FLAG_PLUS]) begin
            sign_ch = "+";
            has_sign = 1'b1;
         end else if (fl[FLAG_SPACE]) begin
            has_sign = 1'b1;
         end
      end
      if (has_sign)
         room--;
      if (fl[FLAG_PREFIX]) begin
         if (w.base == BASE_HEX)
            room -= 2;
         else if (w.base == BASE_OCT)
            room -= 1;
      end

      ndig = 0;
      do begin
         d = mag % radix;
         digits[ndig] = ((d < 10) ? 8'("0" + d) : 8'("A" + d - 10)) | lower_bit;
         ndig++;
         mag = mag / radix;
      end while (mag != 0 && ndig < DIGIT_BUFFER_DEF);

      if (min_digits < ndig)
         min_digits = ndig;
      room -= min_digits;

      if (!fl[FLAG_ZERO] && !fl[FLAG_LEFT]) begin
         while (room > 0) begin
            text.push_back(" ");
            room--;
         end
      end
      if (has_sign)
         text.push_back(sign_ch);
      if (fl[FLAG_PREFIX]) begin
         if (w.base == BASE_OCT) begin
            text.push_back("0");
         end else if (w.base == BASE_HEX) begin
            text.push_back("0");
            text.push_back(8'("X") | lower_bit);
         end
      end
      if (!fl[FLAG_LEFT]) begin
         while (room > 0) begin
            text.push_back(pad_ch);
            room--;
         end
      end
      while (min_digits > ndig) begin
         text.push_back("0");
         min_digits--;
      end
      while (ndig > 0) begin
         ndig--;
         text.push_back(digits[ndig]);
      end
      while (room > 0) begin
         text.push_back(" ");
         room--;
      end

      count = (text.size() > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : text.size();
      for (int i = 0; i < count; i++) begin
         tc.ch = text[i];
         tc.last = (i == count - 1);
         text_expected.push_back(tc);
      end
   endfunction

   function automatic number_word_type make_word(input logic [VALUE_W-1:0] value,
                                                 input int base, input int width,
                                                 input int precision,
                                                 input logic [FLAGS_W-1:0] flags);
      number_word_type w;
      w.value = value;
      w.base = BASE_W'(base);
      w.width = WIDTH_W'(width);
      w.precision = PREC_W'(precision);
      w.flags = flags;
      return w;
   endfunction

   // Drives one word and holds it until the block takes it. Called at a rising edge.
   task automatic send_number(input number_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= w.value;
      req_ch.base <= w.base;
      req_ch.width <= w.width;
      req_ch.precision <= w.precision;
      req_ch.flags <= w.flags;
      do @(posedge clock); while (!req_ch.ready);
      predict_text(w);
   endtask

   // Always lets at least one edge pass, so the next word is driven in a later step.
   task automatic wait_for_text_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (text_expected.size() != 0);
   endtask

   task automatic test_extreme_values();
      send_number(make_word(32'h0, 10, 0, 0, '0));
      send_number(make_word(32'hFFFF_FFFF, 2, 0, 0, '0));
      send_number(make_word(32'hFFFF_FFFF, 16, 0, 0, '0));
      send_number(make_word(32'h8000_0000, 10, 0, 0, F_SIGNED));
      send_number(make_word(32'h7FFF_FFFF, 10, 0, 0, F_SIGNED));
   endtask

   task automatic test_sign_flags();
      send_number(make_word(-32'sd42, 10, 8, 0, F_SIGNED | F_ZERO));
      send_number(make_word(32'd42, 10, 6, 0, F_SIGNED | F_PLUS));
      send_number(make_word(32'd42, 10, 6, 0, F_SIGNED | F_SPACE));
      send_number(make_word(32'd42, 10, 0, 0, F_SIGNED | F_PLUS | F_SPACE));
      send_number(make_word(32'd42, 10, 5, 0, F_PLUS | F_SPACE));
   endtask

   task automatic test_prefix_and_case();
      send_number(make_word(32'h0, 16, 0, 0, F_PREFIX));
      send_number(make_word(32'hBEEF, 16, 10, 0, F_PREFIX | F_LOWER | F_ZERO));
      send_number(make_word(32'hBEEF, 16, 0, 0, F_LOWER));
      send_number(make_word(32'd8, 8, 6, 0, F_PREFIX));
      send_number(make_word(32'd10, 2, 0, 0, F_PREFIX | F_LOWER));
   endtask

   task automatic test_padding_and_limits();
      send_number(make_word(32'd123, 10, 10, 0, F_LEFT | F_ZERO));
      send_number(make_word(32'd123, 10, 10, 5, '0));
      send_number(make_word(-32'sd7, 10, 10, 4, F_SIGNED | F_LEFT));
      // Width beyond the field limit and precision beyond the digit buffer saturate.
      send_number(make_word(32'd5, 3, 63, 0, '0));
      send_number(make_word(32'd1, 2, 48, 63, F_SIGNED | F_PLUS | F_LEFT));
      send_number(make_word(32'hFFFF_FFFF, 7, 0, 40, F_ZERO | F_LOWER | F_PREFIX));
   endtask

   // Out-of-range bases produce no text; a good word follows so the stream keeps moving.
   task automatic test_bad_base();
      send_number(make_word(32'd99, 0, 4, 0, '0));
      send_number(make_word(32'd99, 1, 4, 0, '0));
      send_number(make_word(32'd99, 17, 4, 0, '0));
      send_number(make_word(32'd99, 31, 4, 0, F_SIGNED | F_PREFIX));
      send_number(make_word(32'd99, 9, 4, 0, '0));
   endtask

   function automatic number_word_type random_word();
      number_word_type w;
      int pick;
      case ($urandom_range(5))
         0: w.value = $urandom_range(0, 20);
         1: w.value = -$urandom_range(1, 100);
         2: begin
            pick = $urandom_range(3);
            w.value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h7FFF_FFFF :
                      (pick == 2) ? 32'h8000_0000 : 32'hFFFF_FFFF;
         end
         default: w.value = $urandom;
      endcase
      pick = $urandom_range(19);
      if (pick < 3)
         w.base = BASE_HEX;
      else if (pick < 6)
         w.base = BASE_OCT;
      else if (pick < 9)
         w.base = BASE_W'(10);
      else if (pick < 18)
         w.base = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
      else
         w.base = BASE_W'(($urandom_range(1) == 0) ? $urandom_range(0, 1)
                                                   : $urandom_range(17, 31));
      w.width = WIDTH_W'(($urandom_range(7) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 20));
      w.precision = PREC_W'(($urandom_range(7) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 12));
      w.flags = FLAGS_W'($urandom_range(0, 127));
      return w;
   endfunction

   task automatic test_random_mix(input int num_words);
      number_word_type w;
      int good;
      good = 0;
      while (good < num_words) begin
         w = random_word();
         send_number(w);
         if (w.base >= BASE_MIN && w.base <= BASE_MAX)
            good++;
         // At the halfway point of each phase, and now and then, let the block run completely empty.
         if (good == num_words / 2 || $urandom_range(49) == 0)
            wait_for_text_drain();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      req_ch.base <= BASE_MIN;
      req_ch.width <= '0;
      req_ch.precision <= '0;
      req_ch.flags <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 70;
      test_extreme_values();
      test_sign_flags();
      test_prefix_and_case();
      test_padding_and_limits();
      test_bad_base();
      test_random_mix(80);

      send_idle_pct = 70;
      recv_idle_pct = 26;
      test_random_mix(80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(70);

      wait_for_text_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && text_expected.size() == 0)
         $display("integer_to_padded_text_tb passed");
      else
         $display("integer_to_padded_text_tb failed");
      $finish;
   end

   // Every accepted character word is matched against the oldest queued one.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (text_expected.size() == 0) begin
            report_mismatch("unexpected character", '0, {24'h0, rsp_ch.char_out});
         end else begin
            want = text_expected.pop_front();
            if (rsp_ch.char_out !== want.ch)
               report_mismatch("char_out", 32'(want.ch), 32'(rsp_ch.char_out));
            if (rsp_ch.last !== want.last)
               report_mismatch("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

endmodule

### filelist.f
+incdir+design
design/itpt_pkg.sv
design/itpt_req_if.sv
design/itpt_rsp_if.sv
design/itpt_ram.sv
design/itpt_controller.sv
design/itpt_datapath.sv
design/integer_to_padded_text.sv
tb/integer_to_padded_text_tb.sv
